[src/assert_macros.svh]
// Assertion macros used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define TTU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle
`define TTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ttu_pkg.sv]
// Types, character codes and helpers for the text to unsigned parser
`timescale 1ns / 1ps
package ttu_pkg;

  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int OFFSET_W = 13;
  localparam int DIGIT_W  = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_LIMIT  = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_AUTO   = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_BAD    = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;

  localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd63;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              eos;
  } char_word_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] stop_offset;
    logic                converted;
    logic                range_error;
  } res_flags_t;

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - CH_UP_A + 8'd10;
    end else begin
      d = CHAR_W'(NO_DIGIT);
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

[src/ttu_ifs.sv]
// Handshake channel interfaces for characters, results and the radix register
`timescale 1ns / 1ps
interface ttu_in_if import ttu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

interface ttu_out_if import ttu_pkg::*; #(parameter int VALUE_WIDTH = 32) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [OFFSET_W-1:0]    stop_offset;
  logic                   converted;
  logic                   range_error;

  modport source (output valid, output value, output stop_offset, output converted,
                  output range_error, input ready);
  modport sink (input valid, input value, input stop_offset, input converted,
                input range_error, output ready);
endinterface

interface ttu_cfg_if import ttu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output radix, input ready);
  modport sink (input valid, input radix, output ready);
endinterface

[src/ttu_in_stage.sv]
// Input register holding one character word
`timescale 1ns / 1ps
module ttu_in_stage import ttu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ttu_in_if.sink     in_ch,
  input  logic       advance,
  output logic       word_valid,
  output char_word_t word
);

  logic       valid_r;
  char_word_t word_r;
  logic       take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word_r.code <= in_ch.char_code;
      word_r.eos  <= in_ch.end_of_string;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

[src/ttu_core.sv]
// Parse state machine with digit multiply-add and result formation
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ttu_core import ttu_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_LEN     = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [RADIX_W-1:0]     cfg_radix,
  input  logic                   advance,
  input  char_word_t             word,
  output logic                   res_load,
  output logic [VALUE_WIDTH-1:0] res_value,
  output res_flags_t             res_flags
);

  localparam int POS_W  = $clog2(MAX_LEN + 1);
  localparam int EXT_W  = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
  localparam int PROD_W = VALUE_WIDTH + RADIX_W + 1;

  phase_t                 phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   seen_r, seen_nxt;
  logic [POS_W-1:0]       char_pos_r, char_pos_nxt;
  logic [POS_W-1:0]       end_pos_r, end_pos_nxt;
  logic [RADIX_W-1:0]     radix_r;

  logic                   is_ws;
  logic                   is_sign;
  logic                   is_x;
  logic                   first_char;
  logic                   bad_base;
  logic                   zero_prefix;
  logic [RADIX_W-1:0]     first_base;
  logic [RADIX_W-1:0]     digit_base;
  logic [DIGIT_W-1:0]     digit;
  logic                   no_digit;
  logic [PROD_W-1:0]      prod;
  logic                   prod_ovf;
  logic [POS_W-1:0]       pos_inc;
  logic [EXT_W-1:0]       end_ext;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p >= POS_W'(MAX_LEN)) ? POS_W'(MAX_LEN) : p + 1'b1;
  endfunction

  assign is_ws   = (word.code == CH_SPACE) || (word.code >= CH_TAB && word.code <= CH_CR);
  assign is_sign = (word.code == CH_PLUS) || (word.code == CH_MINUS);
  assign is_x    = (word.code == CH_LO_X) || (word.code == CH_UP_X);

  assign first_char  = (phase_r == PH_SKIP && !is_ws && !is_sign) || (phase_r == PH_SIGN);
  assign bad_base    = (radix_r == BASE_BAD) || (radix_r > BASE_LIMIT);
  assign zero_prefix = ((radix_r == BASE_AUTO) || (radix_r == BASE_HEX)) &&
                       (word.code == CH_ZERO);
  assign first_base  = (radix_r == BASE_AUTO) ? BASE_DEC : radix_r;
  assign digit_base  = first_char ? first_base : base_r;

  assign digit    = digit_value(word.code);
  assign no_digit = RADIX_W'(digit) >= digit_base;
  assign prod     = PROD_W'(acc_r) * PROD_W'(digit_base) + PROD_W'(digit);
  assign prod_ovf = |prod[PROD_W-1:VALUE_WIDTH];
  assign pos_inc  = next_pos(char_pos_r);

  always_comb begin
    logic digit_step;
    digit_step   = 1'b0;
    phase_nxt    = phase_r;
    acc_nxt      = acc_r;
    base_nxt     = base_r;
    neg_nxt      = neg_r;
    ovf_nxt      = ovf_r;
    seen_nxt     = seen_r;
    char_pos_nxt = char_pos_r;
    end_pos_nxt  = end_pos_r;
    if (advance) begin
      if (word.eos) begin
        phase_nxt    = PH_SKIP;
        acc_nxt      = '0;
        base_nxt     = '0;
        neg_nxt      = 1'b0;
        ovf_nxt      = 1'b0;
        seen_nxt     = 1'b0;
        char_pos_nxt = '0;
        end_pos_nxt  = '0;
      end else begin
        char_pos_nxt = pos_inc;
        unique case (phase_r)
          PH_SKIP, PH_SIGN: begin
            if (phase_r == PH_SKIP && is_sign) begin
              neg_nxt   = (word.code == CH_MINUS);
              phase_nxt = PH_SIGN;
            end else if (first_char) begin
              if (bad_base) begin
                phase_nxt = PH_DONE;
              end else if (zero_prefix) begin
                base_nxt    = (radix_r == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                seen_nxt    = 1'b1;
                end_pos_nxt = pos_inc;
                phase_nxt   = PH_ZERO;
              end else begin
                base_nxt   = first_base;
                digit_step = 1'b1;
              end
            end
          end
          PH_ZERO: begin
            if (is_x) begin
              base_nxt    = BASE_HEX;
              seen_nxt    = 1'b0;
              end_pos_nxt = '0;
              phase_nxt   = PH_DIGITS;
            end else begin
              digit_step = 1'b1;
            end
          end
          PH_DIGITS: begin
            digit_step = 1'b1;
          end
          default: begin
          end
        endcase
        if (digit_step) begin
          if (no_digit) begin
            phase_nxt = PH_DONE;
          end else begin
            if (!ovf_r) begin
              if (prod_ovf) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = prod[VALUE_WIDTH-1:0];
              end
            end
            seen_nxt    = 1'b1;
            end_pos_nxt = pos_inc;
            phase_nxt   = PH_DIGITS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SKIP;
      acc_r      <= '0;
      base_r     <= '0;
      neg_r      <= 1'b0;
      ovf_r      <= 1'b0;
      seen_r     <= 1'b0;
      char_pos_r <= '0;
      end_pos_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      acc_r      <= acc_nxt;
      base_r     <= base_nxt;
      neg_r      <= neg_nxt;
      ovf_r      <= ovf_nxt;
      seen_r     <= seen_nxt;
      char_pos_r <= char_pos_nxt;
      end_pos_r  <= end_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_radix;
    end
  end

  assign end_ext  = EXT_W'(end_pos_r);
  assign res_load = advance && word.eos;

  always_comb begin
    if (!seen_r) begin
      res_value = '0;
    end else if (ovf_r) begin
      res_value = '1;
    end else if (neg_r) begin
      res_value = '0 - acc_r;
    end else begin
      res_value = acc_r;
    end
    res_flags.stop_offset = seen_r ? end_ext[OFFSET_W-1:0] : '0;
    res_flags.converted   = seen_r;
    res_flags.range_error = seen_r && ovf_r;
  end

  `TTU_ASSERT(a_ovf_needs_digit, !ovf_r || seen_r, "overflow without a digit")
  `TTU_ASSERT(a_end_before_pos, end_pos_r <= char_pos_r, "stop offset past position")
  `TTU_ASSERT(a_pos_bounded, char_pos_r <= POS_W'(MAX_LEN), "position above limit")
  `TTU_ASSERT_NEXT(a_clear_on_eos, res_load, phase_r == PH_SKIP && !seen_r && acc_r == '0, "state not cleared after terminator")
  `TTU_ASSERT(a_zero_unconverted, !res_load || res_flags.converted || res_value == '0, "nonzero value without conversion")

endmodule

[src/ttu_out_stage.sv]
// Result register driving the output channel
`timescale 1ns / 1ps
module ttu_out_stage import ttu_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  ttu_out_if.source              out_ch,
  input  logic                   load,
  input  logic [VALUE_WIDTH-1:0] value,
  input  res_flags_t             flags,
  output logic                   out_free
);

  logic                   valid_r;
  logic [VALUE_WIDTH-1:0] value_r;
  res_flags_t             flags_r;

  assign out_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= value;
      flags_r <= flags;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.value       = value_r;
  assign out_ch.stop_offset = flags_r.stop_offset;
  assign out_ch.converted   = flags_r.converted;
  assign out_ch.range_error = flags_r.range_error;

endmodule

[src/text_to_unsigned_parser.sv]
// Top level of the streaming text to unsigned integer parser
`timescale 1ns / 1ps
// Takes one character word per cycle, end_of_string marking the terminator, and
// returns one result word per terminator: the value, the stop offset and the
// converted and range_error flags. Throughput is one character every cycle while
// the input is not stalled, set by the combinational multiply-add of the
// accumulator by the base with its overflow check. A terminator's result reaches
// out_ch through the input register, which holds the terminator while the result
// is formed, and then the result register, which presents it.
// The input stalls only when a terminator meets a result that is still waiting.
// The radix register resets to 10, is always ready, and should be written between
// strings. There is no start-up clearing pass.
module text_to_unsigned_parser import ttu_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_LEN     = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  ttu_in_if.sink    in_ch,
  ttu_out_if.source out_ch,
  ttu_cfg_if.sink   cfg_ch
);

  logic                   word_valid;
  char_word_t             word;
  logic                   advance;
  logic                   out_free;
  logic                   res_load;
  logic [VALUE_WIDTH-1:0] res_value;
  res_flags_t             res_flags;

  assign cfg_ch.ready = 1'b1;
  assign advance      = word_valid && (!word.eos || out_free);

  ttu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  ttu_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_LEN     (MAX_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_radix (cfg_ch.radix),
    .advance   (advance),
    .word      (word),
    .res_load  (res_load),
    .res_value (res_value),
    .res_flags (res_flags)
  );

  ttu_out_stage #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (res_load),
    .value    (res_value),
    .flags    (res_flags),
    .out_free (out_free)
  );

endmodule
